// ===== hw/rtl/breakpoint_wave_sample_assert.svh =====
// Assertion macros for the breakpoint waveform sampler checker
`ifndef BREAKPOINT_WAVE_SAMPLE_ASSERT_SVH
`define BREAKPOINT_WAVE_SAMPLE_ASSERT_SVH

// same-cycle implication
`define BWS_ASSERT_NOW(lbl, clk, dis, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define BWS_ASSERT_NEXT(lbl, clk, dis, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hw/rtl/bws_pkg.sv =====
// Shared types, codes and helper functions of the breakpoint waveform sampler
package bws_pkg;

    localparam int unsigned NUM_W = 54;
    localparam int unsigned P1_W  = 44;
    localparam logic [16:0] SAT_MAG = 17'd32768;

    typedef enum logic [1:0] {
        REG_ACTIVE = 2'd0,
        REG_RES    = 2'd1,
        REG_PER    = 2'd2,
        REG_VOL    = 2'd3
    } reg_idx_t;

    typedef enum logic {
        CMD_WRITE  = 1'b0,
        CMD_SAMPLE = 1'b1
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic [4:0]         slot;
        logic [15:0]        pos;
        logic signed [8:0]  level;
        logic [15:0]        sidx;
    } cmd_t;

    typedef struct packed {
        logic [5:0]  active_points;
        logic [15:0] position_resolution;
        logic [15:0] period_samples;
        logic [7:0]  volume;
    } cfg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_SCAN_RD,
        ST_SCAN_CK,
        ST_LD0,
        ST_LD0_W,
        ST_LDP,
        ST_LDP_W,
        ST_LDN,
        ST_LDN_W,
        ST_MUL_A,
        ST_ADD,
        ST_MUL_C,
        ST_OUT
    } back_state_t;

    function automatic logic [16:0] sat_signed(input logic neg, input logic [NUM_W-1:0] mag);
        logic [16:0] m;
        m = (mag > NUM_W'(SAT_MAG)) ? SAT_MAG : mag[16:0];
        return neg ? (17'd0 - m) : m;
    endfunction

    function automatic logic [16:0] level_scaled(input logic signed [8:0] y,
                                                 input logic [7:0] vol);
        logic signed [18:0] s;
        s = 19'(y) * $signed({1'b0, vol, 1'b0});
        if (s > 19'sd32768) begin
            return SAT_MAG;
        end else if (s < -19'sd32768) begin
            return 17'd0 - SAT_MAG;
        end else begin
            return s[16:0];
        end
    endfunction

endpackage

// ===== hw/rtl/bws_ram.sv =====
// Generic single-write, single-read RAM with registered read data
module bws_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/bws_front.sv =====
// Front end: accept, classify and queue transactions; drops writes past MAX_POINTS
module bws_front #(
    parameter int unsigned MAX_POINTS = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_op,
    input  logic [4:0]          s_point_index,
    input  logic [15:0]         s_point_pos,
    input  logic signed [8:0]   s_point_level,
    input  logic [15:0]         s_sample_index,
    output logic                q_avail,
    output bws_pkg::cmd_t       q_head,
    input  logic                q_pop
);
    import bws_pkg::*;

    cmd_t       fifo_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;
    cmd_t       cmd;
    logic       keep, push;

    always_comb begin
        cmd.kind  = s_op ? CMD_SAMPLE : CMD_WRITE;
        cmd.slot  = s_point_index;
        cmd.pos   = s_point_pos;
        cmd.level = s_point_level;
        cmd.sidx  = s_sample_index;
        keep = s_op || (int'(s_point_index) < MAX_POINTS);
    end

    assign s_ready = (cnt_reg != 2'd2);
    assign push    = s_valid && s_ready && keep;
    assign q_avail = (cnt_reg != 2'd0);
    assign q_head  = fifo_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_reg[wr_ptr_reg] <= cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (q_pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, q_pop};
        end
    end

endmodule

// ===== hw/rtl/bws_back.sv =====
// Back end: table writes, position divide, breakpoint scan, interpolation and output
module bws_back #(
    parameter int unsigned MAX_POINTS = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  bws_pkg::cfg_t       cfg,
    input  logic                q_avail,
    input  bws_pkg::cmd_t       q_head,
    output logic                q_pop,
    output logic                m_valid,
    input  logic                m_ready,
    output logic signed [16:0]  m_sample
);
    import bws_pkg::*;

    localparam int unsigned AW = $clog2(MAX_POINTS);
    localparam int unsigned CW = $clog2(MAX_POINTS + 1);

    back_state_t state_reg, state_next;

    logic [NUM_W-1:0]   dq_reg;
    logic [15:0]        rem_reg, dv_reg;
    logic [5:0]         cnt_reg;
    logic               phase_reg;
    logic [31:0]        pos_reg;
    logic [CW-1:0]      c_reg;
    logic signed [8:0]  y0_reg, y1_reg, y2_reg;
    logic [15:0]        x1_reg, x2_reg;
    logic signed [25:0] pa_reg;
    logic signed [42:0] pb_reg;
    logic [15:0]        wmag_reg;
    logic               wneg_reg, neg_reg;
    logic [P1_W-1:0]    p1mag_reg;
    logic [16:0]        out_reg;

    logic [CW-1:0]      n_val;
    logic               ram_we;
    logic [AW-1:0]      ram_waddr, ram_raddr;
    logic [24:0]        ram_rdata;
    logic [15:0]        rd_x;
    logic signed [8:0]  rd_y;
    logic [16:0]        div_t;
    logic               div_ge;
    logic [NUM_W-1:0]   dq_n;
    logic               div_last, scan_hit, scan_end;
    logic signed [32:0] d_val;
    logic signed [16:0] w_val;
    logic signed [9:0]  h_val;
    logic signed [P1_W-1:0] p1_val;

    assign n_val = (int'(cfg.active_points) > MAX_POINTS) ? CW'(MAX_POINTS)
                                                        : CW'(cfg.active_points);
    assign rd_x = ram_rdata[24:9];
    assign rd_y = ram_rdata[8:0];

    assign div_t    = {rem_reg, dq_reg[NUM_W-1]};
    assign div_ge   = div_t >= {1'b0, dv_reg};
    assign dq_n     = {dq_reg[NUM_W-2:0], div_ge};
    assign div_last = (cnt_reg == 6'(NUM_W - 1));

    assign scan_hit = {16'd0, rd_x} > pos_reg;
    assign scan_end = (c_reg + 1'b1) == n_val;

    assign d_val  = $signed({1'b0, pos_reg}) - $signed({17'd0, x1_reg});
    assign w_val  = $signed({1'b0, x2_reg}) - $signed({1'b0, x1_reg});
    assign h_val  = 10'(y2_reg) - 10'(y1_reg);
    assign p1_val = P1_W'(pa_reg) + P1_W'(pb_reg);

    bws_ram #(.WIDTH(25), .DEPTH(MAX_POINTS)) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata ({q_head.pos, q_head.level}),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (q_avail) begin
                    if (q_head.kind == CMD_WRITE) begin
                        state_next = ST_IDLE;
                    end else if (n_val == '0) begin
                        state_next = ST_OUT;
                    end else begin
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                if (div_last) begin
                    state_next = phase_reg ? ST_OUT : ST_SCAN_RD;
                end
            end
            ST_SCAN_RD: state_next = ST_SCAN_CK;
            ST_SCAN_CK: begin
                if (scan_hit || scan_end) begin
                    state_next = ST_LD0;
                end else begin
                    state_next = ST_SCAN_RD;
                end
            end
            ST_LD0:   state_next = ST_LD0_W;
            ST_LD0_W: state_next = (c_reg == '0) ? ST_OUT : ST_LDP;
            ST_LDP:   state_next = ST_LDP_W;
            ST_LDP_W: state_next = (c_reg == n_val) ? ST_MUL_A : ST_LDN;
            ST_LDN:   state_next = ST_LDN_W;
            ST_LDN_W: state_next = ST_MUL_A;
            ST_MUL_A: begin
                if (d_val == '0 || w_val == '0) begin
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD:   state_next = ST_MUL_C;
            ST_MUL_C: state_next = ST_DIV;
            ST_OUT: begin
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        q_pop     = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = AW'(q_head.slot);
        ram_raddr = c_reg[AW-1:0];
        m_valid   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                q_pop  = q_avail;
                ram_we = q_avail && (q_head.kind == CMD_WRITE);
            end
            ST_LD0:  ram_raddr = '0;
            ST_LDP:  ram_raddr = AW'(c_reg - 1'b1);
            ST_OUT:  m_valid = 1'b1;
            default: ram_raddr = c_reg[AW-1:0];
        endcase
    end

    assign m_sample = out_reg;

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                dq_reg    <= NUM_W'(cfg.position_resolution * q_head.sidx);
                dv_reg    <= (cfg.period_samples == 16'd0) ? 16'd1 : cfg.period_samples;
                rem_reg   <= '0;
                cnt_reg   <= '0;
                phase_reg <= 1'b0;
                out_reg   <= '0;
            end
            ST_DIV: begin
                dq_reg  <= dq_n;
                rem_reg <= div_ge ? 16'(div_t - {1'b0, dv_reg}) : div_t[15:0];
                cnt_reg <= cnt_reg + 6'd1;
                if (div_last) begin
                    pos_reg <= dq_n[31:0];
                    c_reg   <= '0;
                    out_reg <= sat_signed(neg_reg, dq_n);
                end
            end
            ST_SCAN_CK: begin
                if (!scan_hit) begin
                    c_reg <= c_reg + 1'b1;
                end
            end
            ST_LD0_W: begin
                y0_reg  <= rd_y;
                out_reg <= level_scaled(rd_y, cfg.volume);
            end
            ST_LDP_W: begin
                x1_reg <= rd_x;
                y1_reg <= rd_y;
                x2_reg <= cfg.position_resolution;
                y2_reg <= y0_reg;
            end
            ST_LDN_W: begin
                x2_reg <= rd_x;
                y2_reg <= rd_y;
            end
            ST_MUL_A: begin
                out_reg  <= (d_val == '0) ? level_scaled(y1_reg, cfg.volume)
                                          : level_scaled(y0_reg, cfg.volume);
                pa_reg   <= 26'(y1_reg) * 26'(w_val);
                pb_reg   <= 43'(h_val) * 43'(d_val);
                wneg_reg <= w_val[16];
                wmag_reg <= w_val[16] ? 16'(-w_val) : w_val[15:0];
            end
            ST_ADD: begin
                neg_reg   <= p1_val[P1_W-1] ^ wneg_reg;
                p1mag_reg <= p1_val[P1_W-1] ? P1_W'(-p1_val) : P1_W'(p1_val);
            end
            ST_MUL_C: begin
                dq_reg    <= NUM_W'(p1mag_reg) * NUM_W'({cfg.volume, 1'b0});
                dv_reg    <= wmag_reg;
                rem_reg   <= '0;
                cnt_reg   <= '0;
                phase_reg <= 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hw/rtl/breakpoint_wave_sample.sv =====
// Top level of the breakpoint waveform sampler: register port, front end and back end
//
//  channel   direction  handshake          payload
//  s_        in         s_valid/s_ready    op, point_index, point_pos, point_level, sample_index
//  m_        out        m_valid/m_ready    sample
//  apb       in/out     psel/penable       pwrite, paddr, pwdata in; prdata out
//
// A breakpoint write is done in the back end's idle state; a sample runs the shared
// bit-serial divider (54 steps, once for the position, once for the interpolation)
// and scans the breakpoint RAM, a read and a check per entry, and no new transaction
// is taken until the sample is through. A two-entry queue keeps s_ready high while the
// back end works or m_valid stalls, until it fills. aresetn is synchronous, active low.
module breakpoint_wave_sample #(
    parameter int unsigned MAX_POINTS = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_op,
    input  logic [4:0]         s_point_index,
    input  logic [15:0]        s_point_pos,
    input  logic signed [8:0]  s_point_level,
    input  logic [15:0]        s_sample_index,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [16:0] m_sample,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import bws_pkg::*;

    cfg_t     cfg_reg;
    reg_idx_t reg_sel;
    logic     q_avail, q_pop;
    cmd_t     q_head;

    assign pready  = 1'b1;
    assign reg_sel = reg_idx_t'(paddr[3:2]);

    always_comb begin
        unique case (reg_sel)
            REG_ACTIVE: prdata = {26'd0, cfg_reg.active_points};
            REG_RES:    prdata = {16'd0, cfg_reg.position_resolution};
            REG_PER:    prdata = {16'd0, cfg_reg.period_samples};
            REG_VOL:    prdata = {24'd0, cfg_reg.volume};
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.active_points       <= 6'd0;
            cfg_reg.position_resolution <= 16'd1;
            cfg_reg.period_samples      <= 16'd1;
            cfg_reg.volume              <= 8'd128;
        end else if (psel && penable && pwrite && pready && paddr[1:0] == 2'd0) begin
            unique case (reg_sel)
                REG_ACTIVE: cfg_reg.active_points       <= pwdata[5:0];
                REG_RES:    cfg_reg.position_resolution <= pwdata[15:0];
                REG_PER:    cfg_reg.period_samples      <= pwdata[15:0];
                REG_VOL:    cfg_reg.volume              <= pwdata[7:0];
                default: begin
                end
            endcase
        end
    end

    bws_front #(.MAX_POINTS(MAX_POINTS)) u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_op           (s_op),
        .s_point_index  (s_point_index),
        .s_point_pos    (s_point_pos),
        .s_point_level  (s_point_level),
        .s_sample_index (s_sample_index),
        .q_avail        (q_avail),
        .q_head         (q_head),
        .q_pop          (q_pop)
    );

    bws_back #(.MAX_POINTS(MAX_POINTS)) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_avail  (q_avail),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_sample (m_sample)
    );

endmodule

// ===== hw/rtl/bws_checker.sv =====
// Port-level checker of the breakpoint waveform sampler and its bind
`include "breakpoint_wave_sample_assert.svh"

module bws_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic signed [16:0] m_sample,
    input logic               psel,
    input logic               penable,
    input logic               pwrite,
    input logic               pready
);

    `BWS_ASSERT_NEXT(a_out_hold, aclk, !aresetn, m_valid && !m_ready, m_valid && $stable(m_sample))
    `BWS_ASSERT_NEXT(a_reset_idle, aclk, 1'b0, !aresetn, !m_valid && s_ready)
    `BWS_ASSERT_NOW(a_sample_range, aclk, !aresetn, m_valid, m_sample <= 17'sd32768 && m_sample >= -17'sd32768)
    `BWS_ASSERT_NOW(a_apb_ready, aclk, !aresetn, psel && penable && pwrite, pready)

endmodule

bind breakpoint_wave_sample bws_checker u_bws_checker (.*);

// ===== tb/breakpoint_wave_sample_checker.sv =====
// Checker for the breakpoint waveform sampler: snoops register writes and transactions, predicts and compares samples
module breakpoint_wave_sample_checker
    import bws_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic               s_op,
    input  logic [4:0]         s_point_index,
    input  logic [15:0]        s_point_pos,
    input  logic signed [8:0]  s_point_level,
    input  logic [15:0]        s_sample_index,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic signed [16:0] m_sample,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    input  logic               pready,
    output int                 errors,
    output int                 pending,
    output int                 samples_seen
);

    localparam int TABLE_DEPTH = 32;

    logic [15:0]        bp_x [TABLE_DEPTH];
    logic signed [8:0]  bp_y [TABLE_DEPTH];
    logic [5:0]         n_active;
    logic [15:0]        resolution;
    logic [15:0]        period;
    logic [7:0]         gain;
    logic signed [16:0] sample_queue [$];

    function automatic logic signed [16:0] clamp_q15(input longint v);
        if (v > 32768) v = 32768;
        if (v < -32768) v = -32768;
        return v[16:0];
    endfunction

    function automatic logic signed [16:0] predict_sample(input logic [15:0] sidx);
        longint n, c, per, pos, x1, y1, x2, y2, w, h, d, vol;
        n = (n_active > TABLE_DEPTH) ? TABLE_DEPTH : n_active;
        vol = gain;
        if (n == 0) return '0;
        per = (period == 0) ? 1 : period;
        pos = (longint'(resolution) * longint'(sidx)) / per;
        for (c = 0; c < n; c++)
            if (longint'(bp_x[c]) > pos) break;
        if (c == 0) return clamp_q15(longint'(bp_y[0]) * vol * 2);
        x1 = bp_x[c-1];
        y1 = bp_y[c-1];
        if (c == n) begin
            x2 = resolution;
            y2 = bp_y[0];
        end else begin
            x2 = bp_x[c];
            y2 = bp_y[c];
        end
        w = x2 - x1;
        h = y2 - y1;
        d = pos - x1;
        if (d == 0) return clamp_q15(y1 * vol * 2);
        if (w == 0) return clamp_q15(longint'(bp_y[0]) * vol * 2);
        return clamp_q15(((y1 * w + h * d) * vol * 2) / w);
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        errors++;
    endtask

    initial begin
        errors = 0;
        pending = 0;
        samples_seen = 0;
    end

    always @(posedge aclk) begin
        logic signed [16:0] want;
        if (!aresetn) begin
            n_active   = '0;
            resolution = 16'd1;
            period     = 16'd1;
            gain       = 8'd128;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (reg_idx_t'(paddr[3:2]))
                    REG_ACTIVE: n_active   = pwdata[5:0];
                    REG_RES:    resolution = pwdata[15:0];
                    REG_PER:    period     = pwdata[15:0];
                    REG_VOL:    gain       = pwdata[7:0];
                endcase
            end
            if (s_valid && s_ready) begin
                if (cmd_kind_t'(s_op) == CMD_WRITE) begin
                    bp_x[s_point_index] = s_point_pos;
                    bp_y[s_point_index] = s_point_level;
                end else begin
                    sample_queue.push_back(predict_sample(s_sample_index));
                end
            end
            if (m_valid && m_ready) begin
                samples_seen++;
                if (sample_queue.size() == 0) begin
                    report_mismatch($sformatf("unexpected sample %0d", m_sample));
                end else begin
                    want = sample_queue.pop_front();
                    if (m_sample !== want)
                        report_mismatch($sformatf("sample got %0d want %0d", m_sample, want));
                end
            end
        end
        pending = sample_queue.size();
    end

endmodule

// ===== tb/breakpoint_wave_sample_tb.sv =====
// Testbench top of the breakpoint waveform sampler: clock, reset, stimulus and verdict
module breakpoint_wave_sample_tb;
    import bws_pkg::*;

    localparam int  N_SLOTS     = 32;
    localparam int  SETTLE      = 400;
    localparam longint LIMIT    = 3000000;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic               s_op;
    logic [4:0]         s_point_index;
    logic [15:0]        s_point_pos;
    logic signed [8:0]  s_point_level;
    logic [15:0]        s_sample_index;
    logic               m_valid;
    logic               m_ready;
    logic signed [16:0] m_sample;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [3:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    int     errors;
    int     pending;
    int     samples_seen;
    int     items_sent;
    int     settings;
    int     burst_left;
    longint cycles;
    logic [15:0] cur_res;
    logic [15:0] cur_per;
    int     cur_n;
    int     ready_mode;

    breakpoint_wave_sample DUT (.*);

    breakpoint_wave_sample_checker u_checker (
        .aclk, .aresetn, .s_valid, .s_ready, .s_op, .s_point_index, .s_point_pos,
        .s_point_level, .s_sample_index, .m_valid, .m_ready, .m_sample, .psel,
        .penable, .pwrite, .paddr, .pwdata, .pready, .errors, .pending, .samples_seen
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (cycles % 97 == 0) ready_mode <= $urandom_range(0, 3);
        case (ready_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= 1'($urandom_range(0, 1));
            2: m_ready <= ($urandom_range(0, 3) == 0);
            default: m_ready <= ((cycles % 8) < 5);
        endcase
    end

    task automatic send_item(input cmd_kind_t kind, input logic [4:0] slot,
                             input logic [15:0] pos, input logic signed [8:0] lvl,
                             input logic [15:0] sidx);
        int gap;
        s_valid        <= 1'b1;
        s_op           <= kind;
        s_point_index  <= slot;
        s_point_pos    <= pos;
        s_point_level  <= lvl;
        s_sample_index <= sidx;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 12);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(input reg_idx_t r, input logic [31:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= v;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic configure(input int n, input int res, input int per, input int vol);
        drain();
        write_reg(REG_ACTIVE, n);
        write_reg(REG_RES, res);
        write_reg(REG_PER, per);
        write_reg(REG_VOL, vol);
        cur_n   = (n > N_SLOTS) ? N_SLOTS : n;
        cur_res = 16'(res);
        cur_per = 16'(per);
        settings++;
    endtask

    task automatic load_points(input int count, input int span);
        int xs[$];
        int k;
        for (k = 0; k < count; k++) begin
            xs.push_back($urandom_range(0, span));
        end
        xs.sort();
        if (count > 2 && $urandom_range(0, 1)) xs[2] = xs[1];
        if (count > 0 && $urandom_range(0, 2) == 0) xs[0] = 0;
        for (k = 0; k < count; k++) begin
            send_item(CMD_WRITE, 5'(k), 16'(xs[k]), 9'($urandom_range(0, 511)), '0);
        end
    endtask

    task automatic random_run(input int count);
        int k;
        logic [15:0] sidx;
        for (k = 0; k < count; k++) begin
            if ($urandom_range(0, 9) == 0) begin
                send_item(CMD_WRITE, 5'($urandom_range(0, N_SLOTS - 1)), 16'($urandom),
                          9'($urandom_range(0, 511)), 16'($urandom));
            end else begin
                sidx = ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                                   : 16'($urandom_range(0, cur_per));
                send_item(CMD_SAMPLE, 5'($urandom), 16'($urandom), 9'($urandom), sidx);
            end
            if (k == count / 2 && $urandom_range(0, 1)) drain();
        end
    endtask

    initial begin
        int k;
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_op           = 1'b0;
        s_point_index  = '0;
        s_point_pos    = '0;
        s_point_level  = '0;
        s_sample_index = '0;
        m_ready        = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        cycles         = 0;
        items_sent     = 0;
        settings       = 0;
        burst_left     = 0;
        ready_mode     = 0;
        cur_n          = 0;
        cur_res        = 16'd1;
        cur_per        = 16'd1;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_item(CMD_SAMPLE, '0, '0, '0, 16'hFFFF);
        send_item(CMD_SAMPLE, 5'h1F, 16'hFFFF, 9'sh100, 16'h0000);
        for (k = 0; k < N_SLOTS; k++) begin
            send_item(CMD_WRITE, 5'(k), 16'(100 + 30 * k), 9'(k * 17 - 256), '0);
        end
        send_item(CMD_WRITE, 5'd3, 16'd190, 9'sd255, '0);
        send_item(CMD_WRITE, 5'd4, 16'd190, -9'sd128, '0);

        configure(6, 1000, 1000, 128);
        send_item(CMD_SAMPLE, '0, '0, '0, 16'd0);
        send_item(CMD_SAMPLE, '0, '0, '0, 16'd99);
        send_item(CMD_SAMPLE, '0, '0, '0, 16'd100);
        send_item(CMD_SAMPLE, '0, '0, '0, 16'd145);
        send_item(CMD_SAMPLE, '0, '0, '0, 16'd190);
        send_item(CMD_SAMPLE, '0, '0, '0, 16'd250);
        send_item(CMD_SAMPLE, '0, '0, '0, 16'd999);
        send_item(CMD_SAMPLE, '0, '0, '0, 16'd1000);
        send_item(CMD_SAMPLE, '0, '0, '0, 16'hFFFF);

        configure(63, 65535, 65535, 255);
        send_item(CMD_SAMPLE, '0, '0, '0, 16'hFFFF);
        send_item(CMD_SAMPLE, '0, '0, '0, 16'h8000);
        load_points(N_SLOTS, 65535);
        random_run(60);

        configure(1, 0, 0, 0);
        random_run(30);

        configure(2, 1000, 100, 128);
        load_points(2, 1000);
        random_run(70);

        configure(32, 40000, 7, 64);
        load_points(N_SLOTS, 40000);
        random_run(70);

        configure(5, 17, 3, 1);
        load_points(5, 17);
        random_run(50);

        repeat (3) begin
            configure($urandom_range(0, 63), $urandom, $urandom, $urandom_range(0, 255));
            load_points(cur_n, int'(cur_res));
            random_run(40);
        end

        drain();
        $display("%0d transactions sent, %0d samples checked, %0d register settings",
                 items_sent, samples_seen, settings);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
